/* rtl/fpsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_pkg: shared types and constants
// Types, register map and codes for the fan PWM soft-ramp controller.
// ----------------------------------------------------------------------------
package fpsr_pkg;

  localparam int unsigned DutyW     = 7;
  localparam int unsigned ValueW    = 8;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 4;

  localparam logic [DutyW-1:0]     DutyCeil         = 7'd100;
  localparam logic [IntervalW-1:0] IntervalMax      = 10'd1023;
  localparam logic [DelayW-1:0]    HoldMax          = 16'hFFFF;

  localparam logic [IntervalW-1:0] RampIntervalRst  = 10'd50;
  localparam logic [DutyW-1:0]     RampStepRst      = 7'd1;
  localparam logic [DelayW-1:0]    StopDelayRst     = 16'd200;
  localparam logic [DutyW-1:0]     DutyLimitRst     = 7'd100;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_DUTY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RUN      = 2'd1,
    ST_STOPPING = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    REG_RAMP_INTERVAL = 2'd0,
    REG_RAMP_STEP     = 2'd1,
    REG_STOP_DELAY    = 2'd2,
    REG_DUTY_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DutyW-1:0] pwm_duty;
    logic [DutyW-1:0] target_level;
    logic [1:0]       run_state;
  } result_t;

endpackage

/* rtl/fpsr_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_cmd_if: command channel
// Valid/ready channel carrying one tick or command beat.
// ----------------------------------------------------------------------------
interface fpsr_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [fpsr_pkg::ValueW-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

/* rtl/fpsr_status_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_status_if: status channel
// Valid/ready channel carrying one duty/target/state result beat.
// ----------------------------------------------------------------------------
interface fpsr_status_if;
  logic                        valid;
  logic                        ready;
  logic [fpsr_pkg::DutyW-1:0]  pwm_duty;
  logic [fpsr_pkg::DutyW-1:0]  target_level;
  logic [1:0]                  run_state;

  modport source (output valid, output pwm_duty, output target_level, output run_state,
                  input ready);
  modport sink   (input valid, input pwm_duty, input target_level, input run_state,
                  output ready);
endinterface

/* rtl/fan_pwm_soft_ramp_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_pwm_soft_ramp_controller_unit: fan PWM soft-ramp controller
// Slew-limits the fan duty toward a target on ticks, ramps to zero on stop,
// holds, then returns to idle; a duty beat sets the duty directly.
//
//   channel  dir  beat contents
//   cmd      in   mode, value
//   status   out  pwm_duty, target_level, run_state
//   apb      in   register writes/reads (4 regs at 4*i)
//
// One beat per cycle while cmd is ready; each updates the state and its result
// enters the two-entry output stage (result, or skid if result is held), so
// cmd stays ready while one result waits. rst is synchronous and clears state
// and registers to defaults. status stalls only block cmd once both are full.
// ----------------------------------------------------------------------------
module fan_pwm_soft_ramp_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  fpsr_cmd_if.sink                       cmd,
  fpsr_status_if.source                  status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpsr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fpsr_pkg::ApbDataW-1:0]  pwdata,
  output logic [fpsr_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  logic [fpsr_pkg::IntervalW-1:0] step_period;
  logic [fpsr_pkg::DutyW-1:0]     step_size;
  logic [fpsr_pkg::DelayW-1:0]    hold_delay;
  logic [fpsr_pkg::DutyW-1:0]     duty_limit;

  fpsr_pkg::state_t               fsm_state, fsm_state_next;
  logic [fpsr_pkg::DutyW-1:0]     current_level, current_level_next;
  logic [fpsr_pkg::DutyW-1:0]     goal_level, goal_level_next;
  logic [fpsr_pkg::IntervalW-1:0] interval_elapsed, interval_elapsed_next;
  logic                           hold_started, hold_started_next;
  logic [fpsr_pkg::DelayW-1:0]    hold_elapsed, hold_elapsed_next;

  fpsr_pkg::result_t              head, skid, result_next;
  logic                           head_valid, skid_valid;

  logic                           cfg_wr;
  fpsr_pkg::reg_idx_t             cfg_idx;
  logic                           push, pop;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = fpsr_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= fpsr_pkg::RampIntervalRst;
      step_size   <= fpsr_pkg::RampStepRst;
      hold_delay  <= fpsr_pkg::StopDelayRst;
      duty_limit  <= fpsr_pkg::DutyLimitRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fpsr_pkg::REG_RAMP_INTERVAL: step_period <= pwdata[fpsr_pkg::IntervalW-1:0];
        fpsr_pkg::REG_RAMP_STEP:     step_size   <= pwdata[fpsr_pkg::DutyW-1:0];
        fpsr_pkg::REG_STOP_DELAY:    hold_delay  <= pwdata[fpsr_pkg::DelayW-1:0];
        fpsr_pkg::REG_DUTY_LIMIT:    duty_limit  <= pwdata[fpsr_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fpsr_pkg::REG_RAMP_INTERVAL:
        prdata = {{(fpsr_pkg::ApbDataW-fpsr_pkg::IntervalW){1'b0}}, step_period};
      fpsr_pkg::REG_RAMP_STEP:
        prdata = {{(fpsr_pkg::ApbDataW-fpsr_pkg::DutyW){1'b0}}, step_size};
      fpsr_pkg::REG_STOP_DELAY:
        prdata = {{(fpsr_pkg::ApbDataW-fpsr_pkg::DelayW){1'b0}}, hold_delay};
      fpsr_pkg::REG_DUTY_LIMIT:
        prdata = {{(fpsr_pkg::ApbDataW-fpsr_pkg::DutyW){1'b0}}, duty_limit};
      default: prdata = '0;
    endcase
  end

  // beat handshake
  assign cmd.ready = !skid_valid;
  assign push      = cmd.valid && cmd.ready;
  assign pop       = status.valid && status.ready;

  // next-state logic
  always_comb begin
    logic [fpsr_pkg::DutyW-1:0]     lim;
    logic [fpsr_pkg::DutyW-1:0]     req;
    logic [fpsr_pkg::IntervalW-1:0] iv_inc;
    logic                           boundary;
    logic [fpsr_pkg::DutyW:0]       up_sum;
    logic [fpsr_pkg::DutyW-1:0]     dn_diff;
    logic [fpsr_pkg::DutyW-1:0]     dn_goal;
    logic [fpsr_pkg::DelayW-1:0]    hold_inc;

    lim = (duty_limit > fpsr_pkg::DutyCeil) ? fpsr_pkg::DutyCeil : duty_limit;
    req = (cmd.value > {1'b0, lim}) ? lim : cmd.value[fpsr_pkg::DutyW-1:0];

    iv_inc   = (interval_elapsed == fpsr_pkg::IntervalMax) ? interval_elapsed
                                                          : interval_elapsed + 1'b1;
    boundary = (iv_inc >= step_period);

    up_sum  = {1'b0, current_level} + {1'b0, step_size};
    dn_diff = (current_level >= step_size) ? current_level - step_size : '0;
    dn_goal = (dn_diff < goal_level) ? goal_level : dn_diff;

    hold_inc = (hold_started && hold_elapsed != fpsr_pkg::HoldMax) ? hold_elapsed + 1'b1
                                                                   : hold_elapsed;

    fsm_state_next        = fsm_state;
    current_level_next    = current_level;
    goal_level_next       = goal_level;
    interval_elapsed_next = interval_elapsed;
    hold_started_next     = hold_started;
    hold_elapsed_next     = hold_elapsed;

    case (fpsr_pkg::mode_t'(cmd.mode))
      fpsr_pkg::MODE_TICK: begin
        if (fsm_state == fpsr_pkg::ST_RUN) begin
          interval_elapsed_next = boundary ? '0 : iv_inc;
          if (boundary) begin
            if (current_level < goal_level) begin
              current_level_next = (up_sum > {1'b0, goal_level}) ? goal_level
                                                                 : up_sum[fpsr_pkg::DutyW-1:0];
            end else if (current_level > goal_level) begin
              current_level_next = dn_goal;
            end
          end
        end else if (fsm_state == fpsr_pkg::ST_STOPPING) begin
          hold_elapsed_next     = hold_inc;
          interval_elapsed_next = boundary ? '0 : iv_inc;
          if (boundary) begin
            if (current_level != '0) begin
              current_level_next = dn_diff;
            end else if (!hold_started) begin
              hold_started_next = 1'b1;
              hold_elapsed_next = '0;
            end else if (hold_inc >= hold_delay) begin
              hold_started_next = 1'b0;
              hold_elapsed_next = '0;
              fsm_state_next    = fpsr_pkg::ST_IDLE;
            end
          end
        end
      end
      fpsr_pkg::MODE_TARGET: begin
        goal_level_next = req;
        if (fsm_state != fpsr_pkg::ST_RUN) begin
          fsm_state_next        = fpsr_pkg::ST_RUN;
          interval_elapsed_next = '0;
          hold_started_next     = 1'b0;
          hold_elapsed_next     = '0;
        end
      end
      fpsr_pkg::MODE_STOP: begin
        if (fsm_state == fpsr_pkg::ST_RUN) begin
          goal_level_next       = '0;
          fsm_state_next        = fpsr_pkg::ST_STOPPING;
          interval_elapsed_next = '0;
          hold_started_next     = 1'b0;
          hold_elapsed_next     = '0;
        end
      end
      default: begin
        current_level_next = req;
      end
    endcase

    result_next.pwm_duty     = current_level_next;
    result_next.target_level = goal_level_next;
    result_next.run_state    = fsm_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state        <= fpsr_pkg::ST_IDLE;
      current_level    <= '0;
      goal_level       <= '0;
      interval_elapsed <= '0;
      hold_started     <= 1'b0;
      hold_elapsed     <= '0;
    end else if (push) begin
      fsm_state        <= fsm_state_next;
      current_level    <= current_level_next;
      goal_level       <= goal_level_next;
      interval_elapsed <= interval_elapsed_next;
      hold_started     <= hold_started_next;
      hold_elapsed     <= hold_elapsed_next;
    end
  end

  // result + skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : result_next;
    end
    if (push) begin
      skid <= result_next;
    end
  end

  assign status.valid        = head_valid;
  assign status.pwm_duty     = head.pwm_duty;
  assign status.target_level = head.target_level;
  assign status.run_state    = head.run_state;

endmodule
